>>> sv/cmwc_pkg.sv
// Shared types and constants for the CMWC random number generator.
// No dependencies; imported by cmwc_random_generator_top (cmwc_ram does not use it).
package cmwc_pkg;

   // Ring depth default (number of 32-bit lag words)
   localparam int unsigned RING_DEPTH_DEFAULT = 4096;

   // Generator constants
   localparam int unsigned MULT_WIDTH  = 15;
   localparam int unsigned PROD_WIDTH  = 47;
   localparam int unsigned CARRY_WIDTH = 30;
   localparam logic [MULT_WIDTH-1:0]  CMWC_MULT   = 15'd18782;
   localparam logic [31:0]            CMWC_BASE   = 32'hFFFF_FFFE;
   localparam logic [CARRY_WIDTH-1:0] CARRY_LIMIT = 30'd809430660;

   // Opcodes
   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_RESTART  = 2'd1;
   localparam logic [1:0] OP_GENERATE = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [11:0] entry_index;
      logic [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [31:0] random_value;
      logic        produced;
   } rsp_type;

endpackage

>>> sv/cmwc_random_generator_top.sv
// CMWC random number generator top level: lag ring RAM, carry and ring pointer.
// Depends on cmwc_pkg and cmwc_ram.
// An accepted transaction passes stage 1, stage 2 and then the output register.
// One transaction per cycle unless the output stalls; a generate's ring read is
// issued at acceptance, the multiply and the carry update each take one stage.
// Reset (synchronous): carry 0, pointer at the last ring entry, pipeline empty.
// The ring itself is not cleared; every entry must be loaded before it is used.
module cmwc_random_generator_top
   import cmwc_pkg::*;
#(
   parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CARRY_WIDTH-1:0] csr_wr_data
);

   localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
   localparam logic [ADDR_W-1:0] RING_LAST = ADDR_W'(RING_DEPTH - 1);

   // Control and handshake
   logic advance;
   logic accept;

   // Configuration
   logic [CARRY_WIDTH-1:0] initial_carry_ff;

   // Ring pointer
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] next_pos;

   // Stage 1: ring read in flight
   logic              s1_valid_ff;
   logic [1:0]        s1_op_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [31:0]       s1_value_ff;
   logic              s1_wr_ok_ff;
   logic [ADDR_W-1:0] s1_addr_in;
   logic              s1_wr_ok_in;
   logic [31:0]       s1_data_fwd;

   // Stage 2: product ready
   logic                  s2_valid_ff;
   logic [1:0]            s2_op_ff;
   logic [ADDR_W-1:0]     s2_addr_ff;
   logic [31:0]           s2_value_ff;
   logic                  s2_wr_ok_ff;
   logic [PROD_WIDTH-1:0] s2_product_ff, s2_product_in;

   // Last ring write, for forwarding
   logic              lw_valid_ff;
   logic [ADDR_W-1:0] lw_addr_ff;
   logic [31:0]       lw_data_ff;

   // Carry and result arithmetic
   logic [CARRY_WIDTH-1:0]  carry_ff, carry_in;
   logic [PROD_WIDTH:0]     t_sum;
   logic [15:0]             c_hi;
   logic [32:0]             x_sum;
   logic                    x_wrap;
   logic [31:0]             x_word;
   logic [15:0]             c_new;
   logic [31:0]             gen_result;
   logic [CARRY_WIDTH-1:0]  restart_carry;

   // RAM ports
   logic              ram_wr_en;
   logic [31:0]       ram_wr_data;
   logic [31:0]       ram_rd_data;

   // Output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   // Whole pipeline moves when the output register can take a new transaction
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_carry_ff <= '0;
      end else if (csr_wr_en) begin
         initial_carry_ff <= csr_wr_data;
      end
   end

   // Advance the ring pointer with wrap
   assign next_pos = (pos_ff == RING_LAST) ? '0 : pos_ff + 1'b1;

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         case (req_data.opcode)
            OP_RESTART:  pos_in = RING_LAST;
            OP_GENERATE: pos_in = next_pos;
            default:     pos_in = pos_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= RING_LAST;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Stage 1 address and load range check
   assign s1_addr_in  = (req_data.opcode == OP_GENERATE) ? next_pos
                                                         : ADDR_W'(req_data.entry_index);
   assign s1_wr_ok_in = (32'(req_data.entry_index) < 32'(RING_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= req_data.opcode;
         s1_addr_ff  <= s1_addr_in;
         s1_value_ff <= req_data.entry_value;
         s1_wr_ok_ff <= s1_wr_ok_in;
      end
   end

   // Forward pending ring writes: a load one transaction ahead, then the
   // write that landed in the same cycle as this read, then the RAM itself
   always_comb begin
      if (s2_valid_ff && (s2_op_ff == OP_LOAD) && s2_wr_ok_ff && (s2_addr_ff == s1_addr_ff)) begin
         s1_data_fwd = s2_value_ff;
      end else if (lw_valid_ff && (lw_addr_ff == s1_addr_ff)) begin
         s1_data_fwd = lw_data_ff;
      end else begin
         s1_data_fwd = ram_rd_data;
      end
   end

   // Multiply the lag word by the generator constant
   assign s2_product_in = PROD_WIDTH'(CMWC_MULT) * PROD_WIDTH'(s1_data_fwd);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_op_ff      <= s1_op_ff;
         s2_addr_ff    <= s1_addr_ff;
         s2_value_ff   <= s1_value_ff;
         s2_wr_ok_ff   <= s1_wr_ok_ff;
         s2_product_ff <= s2_product_in;
      end
   end

   // Add carry, fold the high word back in, complement against the base
   assign t_sum      = (PROD_WIDTH + 1)'(s2_product_ff) + (PROD_WIDTH + 1)'(carry_ff);
   assign c_hi       = t_sum[PROD_WIDTH:32];
   assign x_sum      = {1'b0, t_sum[31:0]} + 33'(c_hi);
   assign x_wrap     = x_sum[32];
   assign x_word     = x_sum[31:0] + 32'(x_wrap);
   assign c_new      = c_hi + 16'(x_wrap);
   assign gen_result = CMWC_BASE - x_word;

   // Saturate the restart carry
   assign restart_carry = (initial_carry_ff >= CARRY_LIMIT) ? (CARRY_LIMIT - 1'b1)
                                                            : initial_carry_ff;

   always_comb begin
      carry_in = carry_ff;
      if (advance && s2_valid_ff) begin
         case (s2_op_ff)
            OP_GENERATE: carry_in = CARRY_WIDTH'(c_new);
            OP_RESTART:  carry_in = restart_carry;
            default:     carry_in = carry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   // Write back generated words and loads, in transaction order
   assign ram_wr_en   = advance && s2_valid_ff &&
                        ((s2_op_ff == OP_GENERATE) || ((s2_op_ff == OP_LOAD) && s2_wr_ok_ff));
   assign ram_wr_data = (s2_op_ff == OP_GENERATE) ? gen_result : s2_value_ff;

   cmwc_ram #(
      .WIDTH (32),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s2_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (advance),
      .rd_addr (next_pos),
      .rd_data (ram_rd_data)
   );

   // Track the last ring write for the forwarding path
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (advance) begin
         lw_valid_ff <= ram_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lw_addr_ff <= s2_addr_ff;
         lw_data_ff <= ram_wr_data;
      end
   end

   // Output register
   always_comb begin
      rsp_data_in.produced     = (s2_op_ff == OP_GENERATE);
      rsp_data_in.random_value = (s2_op_ff == OP_GENERATE) ? gen_result : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Back-to-back generates never touch the same ring entry
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && (s1_op_ff == OP_GENERATE) && (s2_op_ff == OP_GENERATE))
      |-> (s1_addr_ff != s2_addr_ff))
      else $error("adjacent generates hit the same ring entry");

   // Carry stays below the saturation limit
   assert property (@(posedge clock) disable iff (reset)
      carry_ff < CARRY_LIMIT)
      else $error("carry at or above limit");

   // Loads and restarts return a zero word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.produced) |-> (rsp_data_ff.random_value == '0))
      else $error("non-generate result carries a value");

   // A restart points the ring at its last entry
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.opcode == OP_RESTART)) |=> (pos_ff == RING_LAST))
      else $error("restart did not reset ring pointer");

endmodule

>>> sv/cmwc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old contents when read and write hit the same address.
module cmwc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
